// ----- sv/ffbr_pkg.sv -----
`default_nettype none

package ffbr_pkg;

  localparam int NUM_BLOCKS_DEF  = 1024;
  localparam int BLOCK_BYTES_DEF = 4096;

  // Free map bits held in one RAM row and scanned together
  localparam int WORD_BITS = 8;

  localparam int IDX_W   = 10;
  localparam int REQ_W   = 23;
  localparam int START_W = 10;
  localparam int BIU_W   = 11;
  // Request plus rounding term of up to one block less one byte
  localparam int NUM_W   = 24;

  localparam logic [BIU_W-1:0] BIU_RESET = 11'd1024;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_FIND  = 1'b1;

  typedef struct packed {
    logic             command;
    logic [IDX_W-1:0] entry_index;
    logic             entry_used;
    logic [REQ_W-1:0] request_bytes;
  } ffbr_in_t;

  typedef struct packed {
    logic               found;
    logic [START_W-1:0] start_block;
  } ffbr_out_t;

  typedef struct packed {
    logic capture;
    logic clr_en;
    logic div_step;
    logic wr_rd;
    logic wr_commit;
    logic scan_init;
    logic scan_step;
    logic out_load;
  } ffbr_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_last;
    logic need_zero;
    logic lim_zero;
    logic scan_done;
  } ffbr_stat_t;

endpackage

`default_nettype wire

// ----- sv/ffbr_ram.sv -----
`default_nettype none

module ffbr_ram #(
  parameter int WIDTH = ffbr_pkg::WORD_BITS,
  parameter int DEPTH = ffbr_pkg::NUM_BLOCKS_DEF / ffbr_pkg::WORD_BITS
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- sv/ffbr_div.sv -----
`default_nettype none

// Division by a constant through a reciprocal multiply. The numerator is held
// at load and the quotient is registered at the step, so it is ready in the
// cycle after the step. The reciprocal is rounded up, which is exact for every
// numerator of NUM_W bits.
module ffbr_div #(
  parameter int DIVISOR = ffbr_pkg::BLOCK_BYTES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       load,
  input  wire logic                       step,
  input  wire logic [ffbr_pkg::NUM_W-1:0] num,
  output logic      [ffbr_pkg::NUM_W-1:0] quot,
  output logic                            last
);

  localparam int NW = ffbr_pkg::NUM_W;
  localparam int MW = NW + 1;
  localparam int PW = NW + MW;
  localparam int SH = NW + $clog2(DIVISOR);
  localparam longint unsigned RECIP =
    ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

  logic [NW-1:0] num_r;
  logic [NW-1:0] quot_r;
  logic [PW-1:0] prod;

  assign prod = PW'(num_r) * PW'(RECIP);
  assign quot = quot_r;
  assign last = step;

  always_ff @(posedge clk) begin
    if (load) begin
      num_r <= num;
    end
    if (step) begin
      quot_r <= NW'(prod >> SH);
    end
  end

endmodule

`default_nettype wire

// ----- sv/ffbr_dp.sv -----
`default_nettype none

module ffbr_dp #(
  parameter int NUM_BLOCKS  = ffbr_pkg::NUM_BLOCKS_DEF,
  parameter int BLOCK_BYTES = ffbr_pkg::BLOCK_BYTES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire ffbr_pkg::ffbr_in_t         in_data,
  input  wire logic                       cfg_we,
  input  wire logic [ffbr_pkg::BIU_W-1:0] cfg_data,
  input  wire ffbr_pkg::ffbr_cmd_t        cmd,
  output ffbr_pkg::ffbr_stat_t            stat,
  output ffbr_pkg::ffbr_out_t             out_data
);

  localparam int WB     = ffbr_pkg::WORD_BITS;
  localparam int OFS_W  = $clog2(WB);
  localparam int DEPTH  = (NUM_BLOCKS + WB - 1) / WB;
  localparam int ADDR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int SPAN_W = $clog2(DEPTH * WB + 1);
  localparam int NW     = ffbr_pkg::NUM_W;
  localparam int SW     = ffbr_pkg::START_W;

  logic [ffbr_pkg::BIU_W-1:0] biu_r;
  ffbr_pkg::ffbr_in_t         item_r;
  ffbr_pkg::ffbr_out_t        out_r;
  logic [ADDR_W-1:0]          clr_r;
  logic [ADDR_W-1:0]          raddr_r;
  logic [ADDR_W-1:0]          didx_r;
  logic                       dvalid_r;
  logic [SPAN_W-1:0]          run_r;
  logic [SPAN_W-1:0]          rs_r;
  logic                       hit_r;
  logic [SPAN_W-1:0]          start_r;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [WB-1:0]     ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [WB-1:0]     ram_rdata;

  logic [NW-1:0]     need;
  logic              div_last;
  logic [31:0]       idx32;
  logic              wr_ok;
  logic [ADDR_W-1:0] wr_addr;
  logic [OFS_W-1:0]  wr_bit;
  logic [WB-1:0]     mod_word;
  logic [31:0]       limit32;
  logic [SPAN_W-1:0] limit;
  logic [SPAN_W-1:0] base;
  logic [SPAN_W-1:0] run_v;
  logic [SPAN_W-1:0] rs_v;
  logic [SPAN_W-1:0] start_v;
  logic              hit_v;
  logic              exhaust;

  ffbr_div #(
    .DIVISOR(BLOCK_BYTES)
  ) u_div (
    .clk  (clk),
    .load (cmd.capture),
    .step (cmd.div_step),
    .num  (NW'(in_data.request_bytes) + NW'(BLOCK_BYTES - 1)),
    .quot (need),
    .last (div_last)
  );

  ffbr_ram #(
    .WIDTH(WB),
    .DEPTH(DEPTH)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Entry write: read-modify-write of the row holding the entry
  assign idx32   = 32'(item_r.entry_index);
  assign wr_ok   = idx32 < 32'(NUM_BLOCKS);
  assign wr_addr = idx32[OFS_W +: ADDR_W];
  assign wr_bit  = item_r.entry_index[OFS_W-1:0];

  always_comb begin
    mod_word         = ram_rdata;
    mod_word[wr_bit] = item_r.entry_used;
  end

  assign ram_raddr = cmd.wr_rd ? wr_addr : raddr_r;
  assign ram_we    = cmd.clr_en | (cmd.wr_commit & wr_ok);
  assign ram_waddr = cmd.clr_en ? clr_r : wr_addr;
  assign ram_wdata = cmd.clr_en ? '0 : mod_word;

  assign limit32 = (32'(biu_r) > 32'(NUM_BLOCKS)) ? 32'(NUM_BLOCKS) : 32'(biu_r);
  assign limit   = SPAN_W'(limit32);
  assign base    = SPAN_W'({didx_r, OFS_W'(0)});

  // Walk the row that came back from the map, carrying the run across rows
  always_comb begin
    run_v   = run_r;
    rs_v    = rs_r;
    start_v = start_r;
    hit_v   = 1'b0;
    for (int k = 0; k < WB; k++) begin
      logic [SPAN_W-1:0] blk;
      blk = base + SPAN_W'(k);
      if (!hit_v && (blk < limit)) begin
        if (!ram_rdata[k]) begin
          if (run_v == '0) begin
            rs_v = blk;
          end
          run_v = run_v + SPAN_W'(1);
          if (32'(run_v) >= 32'(need)) begin
            hit_v   = 1'b1;
            start_v = rs_v;
          end
        end else begin
          run_v = '0;
        end
      end
    end
  end

  assign exhaust = (base + SPAN_W'(WB)) >= limit;

  assign stat.clr_last  = clr_r == ADDR_W'(DEPTH - 1);
  assign stat.div_last  = div_last;
  assign stat.need_zero = need == '0;
  assign stat.lim_zero  = limit == '0;
  assign stat.scan_done = dvalid_r && (hit_v || exhaust);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      biu_r    <= ffbr_pkg::BIU_RESET;
      clr_r    <= '0;
      dvalid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        biu_r <= cfg_data;
      end
      if (cmd.clr_en) begin
        clr_r <= clr_r + ADDR_W'(1);
      end
      dvalid_r <= cmd.scan_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
    if (cmd.scan_init) begin
      raddr_r <= '0;
      run_r   <= '0;
      rs_r    <= '0;
      hit_r   <= stat.need_zero;
      start_r <= '0;
    end else if (cmd.scan_step) begin
      raddr_r <= raddr_r + ADDR_W'(1);
      didx_r  <= raddr_r;
      // hold the run state until the first row arrives
      if (dvalid_r) begin
        run_r   <= run_v;
        rs_r    <= rs_v;
        hit_r   <= hit_v;
        start_r <= start_v;
      end
    end
    if (cmd.out_load) begin
      out_r.found       <= hit_r;
      out_r.start_block <= hit_r ? SW'(start_r) : '0;
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

// ----- sv/ffbr_ctrl.sv -----
`default_nettype none

module ffbr_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_command,
  output logic                      in_stall,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  input  wire ffbr_pkg::ffbr_stat_t stat,
  output ffbr_pkg::ffbr_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WR_RD,
    S_WR_WR,
    S_DIV,
    S_CHK,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = (in_command == ffbr_pkg::CMD_FIND) ? S_DIV : S_WR_RD;
        end
      end
      S_WR_RD: begin
        cmd.wr_rd = 1'b1;
        state_nxt = S_WR_WR;
      end
      S_WR_WR: begin
        cmd.wr_commit = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        cmd.scan_init = 1'b1;
        state_nxt     = (stat.need_zero || stat.lim_zero) ? S_DONE : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // wait for the output register to drain
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.out_load | (out_valid_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ----- sv/first_fit_block_run_finder_unit.sv -----
`default_nettype none

// First-fit block run finder. A write word sets one free map entry used or
// free and gives no result; it reads the row holding the entry, then writes
// it back. A find word rounds its byte count up to whole blocks and returns
// the lowest start block of a run of that many free blocks within the first
// blocks_in_use entries, or found = 0. The free map is scanned 8 blocks a
// cycle from a RAM with registered read, after a reciprocal multiplication
// for the rounding; the scan is skipped when the block count or the scan
// range is zero, and a result may wait while the output is stalled. After
// reset the map is cleared one 8-block row a cycle while no word is accepted;
// configuration writes are taken at any time.
module first_fit_block_run_finder_unit #(
  parameter int NUM_BLOCKS  = ffbr_pkg::NUM_BLOCKS_DEF,
  parameter int BLOCK_BYTES = ffbr_pkg::BLOCK_BYTES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire ffbr_pkg::ffbr_in_t         in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output ffbr_pkg::ffbr_out_t             out_data,
  input  wire logic                       cfg_we,
  input  wire logic [ffbr_pkg::BIU_W-1:0] cfg_data
);

  ffbr_pkg::ffbr_cmd_t  cmd;
  ffbr_pkg::ffbr_stat_t stat;

  ffbr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_command(in_data.command),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ffbr_dp #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .cmd     (cmd),
    .stat    (stat),
    .out_data(out_data)
  );

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

  localparam int DIR_N          = 24;
  localparam int NUM_PHASES     = 7;
  localparam int WORDS_PER_PHASE = 250;
  localparam int MAX_BURST      = 8;
  localparam int SETTLE_CYCLES  = 16;

  typedef struct {
    ffbr_pkg::ffbr_in_t  word;
    bit                  typed;
    ffbr_pkg::ffbr_out_t want;
  } dir_row_t;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  ffbr_pkg::ffbr_in_t            in_data   = '0;
  logic                          out_stall = 1'b0;
  logic                          cfg_we    = 1'b0;
  logic [ffbr_pkg::BIU_W-1:0]    cfg_data  = '0;
  logic                          in_stall;
  logic                          out_valid;
  ffbr_pkg::ffbr_out_t           out_data;

  // Mirror of the block: free map, scan range and the runs still owed
  bit                            block_taken [ffbr_pkg::NUM_BLOCKS_DEF];
  logic [ffbr_pkg::BIU_W-1:0]    scan_blocks = ffbr_pkg::BIU_RESET;
  ffbr_pkg::ffbr_out_t           pending_runs [$];
  int                            mismatch_count = 0;
  bit                            idle_en = 1'b1;
  int                            stall_left = 0;
  dir_row_t                      dir_rows [DIR_N];

  first_fit_block_run_finder_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #25_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic ffbr_pkg::ffbr_out_t find_first_run(
    input logic [ffbr_pkg::REQ_W-1:0] bytes
  );
    int                  need;
    int                  lim;
    int                  run;
    int                  run_start;
    ffbr_pkg::ffbr_out_t r;
    r = '0;
    need = (int'(bytes) + ffbr_pkg::BLOCK_BYTES_DEF - 1) / ffbr_pkg::BLOCK_BYTES_DEF;
    lim = (scan_blocks > ffbr_pkg::NUM_BLOCKS_DEF) ? ffbr_pkg::NUM_BLOCKS_DEF
                                                   : int'(scan_blocks);
    if (need == 0) begin
      r.found = 1'b1;
      return r;
    end
    if (need > lim) return r;
    run = 0;
    run_start = 0;
    for (int i = 0; i < lim; i++) begin
      if (block_taken[i]) begin
        run = 0;
      end else begin
        if (run == 0) run_start = i;
        run++;
        if (run >= need) begin
          r.found = 1'b1;
          r.start_block = ffbr_pkg::START_W'(run_start);
          return r;
        end
      end
    end
    return r;
  endfunction

  function automatic dir_row_t dir_entry(input logic cmd, input int idx, input logic used,
                                         input int bytes, input bit typed,
                                         input logic found, input int start);
    dir_row_t d;
    d.word.command       = cmd;
    d.word.entry_index   = ffbr_pkg::IDX_W'(idx);
    d.word.entry_used    = used;
    d.word.request_bytes = ffbr_pkg::REQ_W'(bytes);
    d.typed              = typed;
    d.want.found         = found;
    d.want.start_block   = ffbr_pkg::START_W'(start);
    return d;
  endfunction

  function automatic ffbr_pkg::ffbr_in_t random_word(input int lim, input int pct);
    ffbr_pkg::ffbr_in_t w;
    int                 span;
    int                 nb;
    int                 pick;
    w.command       = ffbr_pkg::CMD_FIND;
    w.entry_index   = ffbr_pkg::IDX_W'($urandom_range(ffbr_pkg::NUM_BLOCKS_DEF - 1));
    w.entry_used    = 1'($urandom_range(1));
    w.request_bytes = ffbr_pkg::REQ_W'($urandom_range(23'h7FFFFF));
    span = (lim < 1) ? 1 : ((lim > ffbr_pkg::NUM_BLOCKS_DEF) ? ffbr_pkg::NUM_BLOCKS_DEF
                                                             : lim);
    if ($urandom_range(99) < 55) begin
      w.command = ffbr_pkg::CMD_WRITE;
      // keep most writes inside the scanned range so they shape the runs
      if ($urandom_range(9) < 8) w.entry_index = ffbr_pkg::IDX_W'($urandom_range(span - 1));
      w.entry_used = ($urandom_range(99) < pct);
    end else begin
      pick = $urandom_range(9);
      if (pick == 0) begin
        w.request_bytes = '0;
      end else if (pick <= 3) begin
        // straddle the scan range edge
        nb = span + $urandom_range(2) - 1;
        w.request_bytes = ffbr_pkg::REQ_W'(nb * ffbr_pkg::BLOCK_BYTES_DEF
                                           - $urandom_range(1));
      end else if (pick <= 8) begin
        nb = $urandom_range(1, 12);
        w.request_bytes = ffbr_pkg::REQ_W'((nb - 1) * ffbr_pkg::BLOCK_BYTES_DEF
                                           + $urandom_range(1, ffbr_pkg::BLOCK_BYTES_DEF));
      end
    end
    return w;
  endfunction

  task automatic send_word(input ffbr_pkg::ffbr_in_t w, input bit typed,
                           input ffbr_pkg::ffbr_out_t want);
    if (idle_en && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, MAX_BURST)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    if (w.command == ffbr_pkg::CMD_WRITE)
      block_taken[w.entry_index] = w.entry_used;
    else
      pending_runs.push_back(typed ? want : find_first_run(w.request_bytes));
  endtask

  task automatic set_limit(input logic [ffbr_pkg::BIU_W-1:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    scan_blocks = v;
  endtask

  // Drop valid, wait for every owed result, then let a trailing write finish
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (pending_runs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!idle_en) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else begin
      out_stall <= ($urandom_range(2) == 0);
      stall_left = $urandom_range(MAX_BURST - 1);
    end
  end

  always @(posedge clk) begin
    ffbr_pkg::ffbr_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_runs.size() == 0) begin
        $display("%0t: unexpected word: expected none, got found=%0b start_block=%0d",
                 $time, out_data.found, out_data.start_block);
        mismatch_count++;
      end else begin
        want = pending_runs.pop_front();
        if (out_data.found !== want.found) begin
          $display("%0t: found: expected %0b, got %0b", $time, want.found, out_data.found);
          mismatch_count++;
        end
        if (out_data.start_block !== want.start_block) begin
          $display("%0t: start_block: expected %0d, got %0d",
                   $time, want.start_block, out_data.start_block);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int lims [NUM_PHASES];
    int pcts [NUM_PHASES];
    bit idles [NUM_PHASES];
    // after reset the whole map is free and the scan covers all 1024 blocks
    dir_rows = '{
      dir_entry(ffbr_pkg::CMD_FIND,     0, 1'b0,        0,       1'b1, 1'b1, 0),
      dir_entry(ffbr_pkg::CMD_FIND,     0, 1'b0,        1,       1'b1, 1'b1, 0),
      dir_entry(ffbr_pkg::CMD_FIND,  1023, 1'b1,  4194304,       1'b1, 1'b1, 0),
      dir_entry(ffbr_pkg::CMD_FIND,     0, 1'b0,  4194305,       1'b1, 1'b0, 0),
      dir_entry(ffbr_pkg::CMD_FIND,     0, 1'b0, 23'h7FFFFF,     1'b1, 1'b0, 0),
      dir_entry(ffbr_pkg::CMD_WRITE,    0, 1'b1, 23'h7FFFFF,     1'b0, 1'b0, 0),
      dir_entry(ffbr_pkg::CMD_FIND,     0, 1'b0,     4096,       1'b0, 1'b0, 0),
      dir_entry(ffbr_pkg::CMD_WRITE, 1023, 1'b1,        0,       1'b0, 1'b0, 0),
      dir_entry(ffbr_pkg::CMD_FIND,     0, 1'b0, 4096 * 1022,    1'b0, 1'b0, 0),
      dir_entry(ffbr_pkg::CMD_FIND,     0, 1'b0, 4096 * 1022 + 1, 1'b0, 1'b0, 0),
      dir_entry(ffbr_pkg::CMD_WRITE,  512, 1'b1,        0,       1'b0, 1'b0, 0),
      dir_entry(ffbr_pkg::CMD_FIND,     0, 1'b0, 4096 * 511,     1'b0, 1'b0, 0),
      dir_entry(ffbr_pkg::CMD_FIND,     0, 1'b0, 4096 * 512,     1'b0, 1'b0, 0),
      dir_entry(ffbr_pkg::CMD_WRITE,    0, 1'b0,        0,       1'b0, 1'b0, 0),
      dir_entry(ffbr_pkg::CMD_FIND,     0, 1'b0, 4096 * 512,     1'b0, 1'b0, 0),
      dir_entry(ffbr_pkg::CMD_WRITE, 10'h2AA, 1'b1,     0,       1'b0, 1'b0, 0),
      dir_entry(ffbr_pkg::CMD_WRITE, 10'h155, 1'b1,     0,       1'b0, 1'b0, 0),
      dir_entry(ffbr_pkg::CMD_FIND,     0, 1'b0,     4095,       1'b0, 1'b0, 0),
      dir_entry(ffbr_pkg::CMD_FIND,     0, 1'b0,     4097,       1'b0, 1'b0, 0),
      dir_entry(ffbr_pkg::CMD_WRITE, 1023, 1'b0,        0,       1'b0, 1'b0, 0),
      dir_entry(ffbr_pkg::CMD_WRITE,  512, 1'b0,        0,       1'b0, 1'b0, 0),
      dir_entry(ffbr_pkg::CMD_WRITE, 10'h2AA, 1'b0,     0,       1'b0, 1'b0, 0),
      dir_entry(ffbr_pkg::CMD_WRITE, 10'h155, 1'b0,     0,       1'b0, 1'b0, 0),
      dir_entry(ffbr_pkg::CMD_FIND,     0, 1'b0,  4194304,       1'b0, 1'b0, 0)
    };
    lims  = '{2047, 1, 0, 9, 100, 0, 1024};
    pcts  = '{20, 50, 50, 30, 25, 15, 10};
    idles = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    lims[5] = $urandom_range(2, ffbr_pkg::NUM_BLOCKS_DEF - 1);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_N; i++)
      send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_and_settle();
      set_limit(ffbr_pkg::BIU_W'(lims[p]));
      idle_en <= idles[p];
      for (int k = 0; k < WORDS_PER_PHASE; k++)
        send_word(random_word(lims[p], pcts[p]), 1'b0, '0);
    end
    drain_and_settle();

    if (mismatch_count == 0 && pending_runs.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
